### hw/rtl/masd_pkg.sv
// Package: shared types and constants for the moving-average slew display block.
`default_nettype none

package masd_pkg;

    // Field widths
    localparam int VAL_W     = 16;
    localparam int DISP_W    = 10;
    localparam int CNT_W     = 8;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int STEP_W    = 4;

    // Default window length
    localparam int WINDOW_LEN_DEF = 12;

    // Request commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_LIMIT    = 1'd1;

    // Configuration reset values
    localparam logic [CNT_W-1:0]  AVG_INTERVAL_RST = 8'd100;
    localparam logic [DISP_W-1:0] DISP_LIMIT_RST   = 10'd532;

    // Target scaling: floor(avg * 3500 / 1024)
    localparam int                SCALE_PROD_W = 28;
    localparam logic [11:0]       SCALE_MUL    = 12'd3500;
    localparam int                SCALE_SHIFT  = 10;

    // Slew control
    localparam logic [DISP_W-1:0] BIG_GAP   = 10'd100;
    localparam logic [STEP_W-1:0] BIG_STEP  = 4'd12;
    localparam logic [CNT_W-1:0]  FAST_RATE = 8'd70;
    localparam logic [CNT_W-1:0]  SLOW_RATE = 8'd200;

    // Divide by ten for gaps up to 100: (x * 205) >> 11
    localparam int               DIV10_IN_W  = 7;
    localparam int               DIV10_PROD_W = 15;
    localparam logic [7:0]       DIV10_MUL   = 8'd205;
    localparam int               DIV10_SHIFT = 11;

    typedef struct packed {
        logic             command;
        logic [VAL_W-1:0] sample;
    } masd_in_t;

    typedef struct packed {
        logic [DISP_W-1:0] shown_value;
        logic [VAL_W-1:0]  window_average;
    } masd_out_t;

endpackage

`default_nettype wire

### hw/rtl/moving_average_slew_display.sv
// Top level: moving-average window and slew-limited display stepper.
// Path from request acceptance to result valid: input register, window stage, scaling stage,
// display stage into the result register. Throughput: one request per cycle when unstalled.
// Stages advance independently, so bubbles close up; the critical paths are the running-sum
// add with the reciprocal multiply and the x3500 scale.
// Reset (rst_n, async, active low): state clears, interval 100, limit 532, pipeline empties.
`default_nettype none

module moving_average_slew_display #(
    parameter int WINDOW_LEN = masd_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // request channel
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire masd_pkg::masd_in_t                  item,
    // result channel
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output masd_pkg::masd_out_t                      result,
    // configuration write port
    input  wire logic                                cfg_write_en,
    input  wire logic [masd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [masd_pkg::CFG_W-1:0]          cfg_data
);
    import masd_pkg::*;

    // Derived sizes for the window sum and the divide by WINDOW_LEN
    localparam int LEN_LOG   = $clog2(WINDOW_LEN);
    localparam int SUM_W     = VAL_W + LEN_LOG;
    localparam int DIV_SHIFT = SUM_W + LEN_LOG;
    localparam int RECIP_W   = SUM_W + 2;
    localparam int AVG_PROD_W = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    // Configuration registers
    logic [CNT_W-1:0]  interval_reg;
    logic [DISP_W-1:0] limit_reg;

    // Pipeline occupancy and moves
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic mv1, mv2, mv3, acc;

    // Stage payloads
    masd_in_t          item_reg;
    logic              r1_tick_reg;
    logic              r2_tick_reg;
    logic [VAL_W-1:0]  r2_avg_reg;
    logic [DISP_W-1:0] r2_target_reg;
    masd_out_t         result_reg;

    // Averaging state
    logic [VAL_W-1:0]  latest_reg;
    logic [VAL_W-1:0]  win_reg [WINDOW_LEN];
    logic [SUM_W-1:0]  sum_reg;
    logic [VAL_W-1:0]  avg_reg;
    logic [CNT_W-1:0]  acnt_reg;

    // Display state
    logic [DISP_W-1:0] disp_reg;
    logic [CNT_W-1:0]  dcnt_reg;
    logic [CNT_W-1:0]  rate_reg;

    // Handshake and stage moves
    assign mv3 = v2_reg && (!v3_reg || !result_stall);
    assign mv2 = v1_reg && (!v2_reg || mv3);
    assign mv1 = v0_reg && (!v1_reg || mv2);
    assign item_stall = v0_reg && !mv1;
    assign acc = item_valid && !item_stall;
    assign result_valid = v3_reg;
    assign result = result_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= AVG_INTERVAL_RST;
            limit_reg    <= DISP_LIMIT_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_AVERAGE_INTERVAL: interval_reg <= cfg_data[CNT_W-1:0];
                REG_DISPLAY_LIMIT:    limit_reg    <= cfg_data[DISP_W-1:0];
            endcase
        end
    end

    // Occupancy bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (acc)
                v0_reg <= 1'b1;
            else if (mv1)
                v0_reg <= 1'b0;
            if (mv1)
                v1_reg <= 1'b1;
            else if (mv2)
                v1_reg <= 1'b0;
            if (mv2)
                v2_reg <= 1'b1;
            else if (mv3)
                v2_reg <= 1'b0;
            if (mv3)
                v3_reg <= 1'b1;
            else if (!result_stall)
                v3_reg <= 1'b0;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (acc)
            item_reg <= item;
    end

    // Window stage: counter, running sum, divide by WINDOW_LEN via reciprocal
    logic                  tick_a;
    logic [CNT_W-1:0]      acnt_inc;
    logic                  advance_a;
    logic [SUM_W-1:0]      sum_next;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [VAL_W-1:0]      avg_calc;

    assign tick_a    = item_reg.command == CMD_TICK;
    assign acnt_inc  = acnt_reg + CNT_W'(1);
    assign advance_a = tick_a && (acnt_inc > interval_reg);
    assign sum_next  = sum_reg - SUM_W'(win_reg[0]) + SUM_W'(latest_reg);
    assign avg_prod  = AVG_PROD_W'(sum_next) * AVG_PROD_W'(RECIP);
    assign avg_calc  = avg_prod[DIV_SHIFT +: VAL_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latest_reg <= '0;
            sum_reg    <= '0;
            avg_reg    <= '0;
            acnt_reg   <= '0;
            for (int k = 0; k < WINDOW_LEN; k++)
                win_reg[k] <= '0;
        end
        else if (mv1)
        begin
            if (!tick_a)
                latest_reg <= item_reg.sample;
            else if (advance_a)
            begin
                acnt_reg <= '0;
                sum_reg  <= sum_next;
                avg_reg  <= avg_calc;
                for (int k = 0; k < WINDOW_LEN - 1; k++)
                    win_reg[k] <= win_reg[k + 1];
                win_reg[WINDOW_LEN - 1] <= latest_reg;
            end
            else
                acnt_reg <= acnt_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mv1)
            r1_tick_reg <= tick_a;
    end

    // Scaling stage: target = min(floor(avg * 3500 / 1024), limit)
    logic [SCALE_PROD_W-1:0]             scale_prod;
    logic [SCALE_PROD_W-SCALE_SHIFT-1:0] target_raw;
    logic [DISP_W-1:0]                   target_b;

    assign scale_prod = SCALE_PROD_W'(avg_reg) * SCALE_PROD_W'(SCALE_MUL);
    assign target_raw = scale_prod[SCALE_PROD_W-1:SCALE_SHIFT];
    assign target_b   = (target_raw > (SCALE_PROD_W-SCALE_SHIFT)'(limit_reg))
                        ? limit_reg : target_raw[DISP_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mv2)
        begin
            r2_tick_reg   <= r1_tick_reg;
            r2_avg_reg    <= avg_reg;
            r2_target_reg <= target_b;
        end
    end

    // Display stage: slew toward target
    logic [CNT_W-1:0]        dcnt_inc;
    logic                    dstep;
    logic                    above, below;
    logic [DISP_W-1:0]       gap;
    logic                    big;
    logic [DIV10_PROD_W-1:0] div10_prod;
    logic [STEP_W-1:0]       small_q;
    logic [STEP_W-1:0]       step;
    logic [STEP_W-1:0]       down;
    logic [DISP_W-1:0]       disp_step;
    logic                    do_move;
    logic [DISP_W-1:0]       disp_next;

    assign dcnt_inc   = dcnt_reg + CNT_W'(1);
    assign dstep      = r2_tick_reg && (dcnt_inc > rate_reg);
    assign above      = disp_reg > r2_target_reg;
    assign below      = disp_reg < r2_target_reg;
    assign gap        = above ? (disp_reg - r2_target_reg) : (r2_target_reg - disp_reg);
    assign big        = gap > BIG_GAP;
    // gap is at most 100 whenever the quotient is used
    assign div10_prod = DIV10_PROD_W'(gap[DIV10_IN_W-1:0]) * DIV10_PROD_W'(DIV10_MUL);
    assign small_q    = div10_prod[DIV10_SHIFT +: STEP_W];
    assign step       = big ? BIG_STEP : small_q + STEP_W'(1);
    // downward steps are halved plus one; they never pass the target
    assign down       = {1'b0, step[STEP_W-1:1]} + STEP_W'(1);
    assign disp_step  = above ? (disp_reg - DISP_W'(down)) : (disp_reg + DISP_W'(step));
    assign do_move    = dstep && (above || below);
    assign disp_next  = do_move ? disp_step : disp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_reg <= '0;
            dcnt_reg <= '0;
            rate_reg <= '0;
        end
        else if (mv3 && r2_tick_reg)
        begin
            dcnt_reg <= dstep ? '0 : dcnt_inc;
            if (do_move)
            begin
                disp_reg <= disp_step;
                rate_reg <= big ? FAST_RATE : SLOW_RATE;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (mv3)
        begin
            result_reg.shown_value    <= disp_next;
            result_reg.window_average <= r2_avg_reg;
        end
    end

    // Checks
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> v0_reg)
        else $error("accepted request not held in input register");

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !v0_reg |-> !item_stall)
        else $error("stall raised with empty input register");

    a_dcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= rate_reg)
        else $error("display tick count above display rate");

    a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !result_stall && !v2_reg |=> !v3_reg)
        else $error("taken result not cleared");

endmodule

`default_nettype wire

### dv/slew_display_checker.sv
// Checker: watches the request, result and register ports, predicts each reading and compares.
module slew_display_checker #(
    parameter int WINDOW_LEN = masd_pkg::WINDOW_LEN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  logic                              item_stall,
    input  masd_pkg::masd_in_t                item,
    input  logic                              result_valid,
    input  logic                              result_stall,
    input  masd_pkg::masd_out_t               result,
    input  logic                              cfg_write_en,
    input  logic [masd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [masd_pkg::CFG_W-1:0]        cfg_data,
    output int                                mismatch_count,
    output int                                awaiting_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import masd_pkg::*;

    // Predicted block state
    logic [VAL_W-1:0]  held_sample;
    logic [VAL_W-1:0]  window_q [WINDOW_LEN];
    logic [VAL_W-1:0]  avg_q;
    logic [DISP_W-1:0] shown_q;
    logic [CNT_W-1:0]  avg_ticks;
    logic [CNT_W-1:0]  disp_ticks;
    logic [CNT_W-1:0]  step_period;

    // Register copies
    logic [CNT_W-1:0]  interval_cfg;
    logic [DISP_W-1:0] limit_cfg;

    // Readings still owed by the block, oldest first
    masd_out_t expected_readings[$];

    task automatic clear_model();
        held_sample  = '0;
        avg_q        = '0;
        shown_q      = '0;
        avg_ticks    = '0;
        disp_ticks   = '0;
        step_period  = '0;
        interval_cfg = AVG_INTERVAL_RST;
        limit_cfg    = DISP_LIMIT_RST;
        for (int k = 0; k < WINDOW_LEN; k++)
            window_q[k] = '0;
    endtask

    // Step size for a gap; also picks the next display period
    task automatic slew_step(input int unsigned gap, output int unsigned step);
        if (gap > BIG_GAP)
        begin
            step_period = FAST_RATE;
            step        = BIG_STEP;
        end
        else
        begin
            step_period = SLOW_RATE;
            step        = gap / 10 + 1;
        end
    endtask

    // Move the display toward the scaled, clamped average
    task automatic move_display();
        int unsigned target;
        int unsigned step;
        target = avg_q;
        target = (target * SCALE_MUL) >> SCALE_SHIFT;
        if (target > limit_cfg)
            target = limit_cfg;
        // downward moves take half the step plus one
        if (shown_q > target)
        begin
            slew_step(shown_q - target, step);
            shown_q = DISP_W'(shown_q - (step / 2 + 1));
        end
        if (shown_q < target)
        begin
            slew_step(target - shown_q, step);
            shown_q = DISP_W'(shown_q + step);
        end
    endtask

    // Apply one request to the predicted state and form its reading
    task automatic predict_request(input masd_in_t req, output masd_out_t reading);
        int unsigned total;
        if (req.command == CMD_SAMPLE)
            held_sample = req.sample;
        else
        begin
            // averaging counter, 8-bit wrap
            avg_ticks = avg_ticks + 1'b1;
            if (avg_ticks > interval_cfg)
            begin
                avg_ticks = '0;
                total     = 0;
                for (int k = 0; k + 1 < WINDOW_LEN; k++)
                begin
                    window_q[k] = window_q[k + 1];
                    total       = total + window_q[k];
                end
                window_q[WINDOW_LEN - 1] = held_sample;
                total = total + held_sample;
                avg_q = VAL_W'(total / WINDOW_LEN);
            end
            // display counter, 8-bit wrap
            disp_ticks = disp_ticks + 1'b1;
            if (disp_ticks > step_period)
            begin
                disp_ticks = '0;
                move_display();
            end
        end
        reading.shown_value    = shown_q;
        reading.window_average = avg_q;
    endtask

    // Sample all channels at the rising edge
    always @(posedge clk)
    begin : watch
        masd_out_t predicted;
        masd_out_t oldest;
        if (!rst_n)
        begin
            clear_model();
            expected_readings.delete();
            mismatch_count = 0;
            awaiting_count = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_AVERAGE_INTERVAL: interval_cfg = cfg_data[CNT_W-1:0];
                    REG_DISPLAY_LIMIT:    limit_cfg    = cfg_data[DISP_W-1:0];
                    default:              ;
                endcase
            end

            // compare an accepted result with the oldest prediction
            if (result_valid && !result_stall)
            begin
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: unexpected result shown_value %0d window_average %0d",
                             $time, result.shown_value, result.window_average);
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_readings.pop_front();
                    if (result.shown_value !== oldest.shown_value)
                    begin
                        $display("%0t: shown_value expected %0d actual %0d",
                                 $time, oldest.shown_value, result.shown_value);
                        mismatch_count++;
                    end
                    if (result.window_average !== oldest.window_average)
                    begin
                        $display("%0t: window_average expected %0d actual %0d",
                                 $time, oldest.window_average, result.window_average);
                        mismatch_count++;
                    end
                end
            end

            // predict an accepted request
            if (item_valid && !item_stall)
            begin
                predict_request(item, predicted);
                expected_readings.push_back(predicted);
            end

            awaiting_count = expected_readings.size();
        end
    end

endmodule

### dv/testbench.sv
// Testbench top: clock, reset, request and register stimulus, and the final verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import masd_pkg::*;

    localparam int WINDOW = WINDOW_LEN_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    masd_in_t             item;
    logic                 result_valid;
    logic                 result_stall;
    masd_out_t            result;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int mismatch_count;
    int awaiting_count;
    int cycle_count;
    bit steady = 1'b0;

    moving_average_slew_display #(.WINDOW_LEN(WINDOW)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    slew_display_checker #(.WINDOW_LEN(WINDOW)) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .item           (item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .result         (result),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .awaiting_count (awaiting_count)
    );

    // 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result back-pressure, about a third of cycles unless in a steady stretch
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            result_stall <= !steady && ($urandom_range(0, 99) < 33);
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Present one request, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_request(input logic cmd, input logic [VAL_W-1:0] value);
        int gap;
        masd_in_t req;
        gap = 0;
        if (!steady)
            while ($urandom_range(0, 99) < 33)
                gap++;
        req.command = cmd;
        req.sample  = value;
        @(negedge clk);
        while (gap > 0)
        begin
            item_valid <= 1'b0;
            gap--;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= req;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Drop valid and wait until every reading has come back
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (awaiting_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Extremes now and then, mostly random values up to a ceiling
    function automatic logic [VAL_W-1:0] pick_sample(input int unsigned ceiling);
        case ($urandom_range(0, 4))
            0:       pick_sample = '0;
            1:       pick_sample = VAL_W'(ceiling);
            default: pick_sample = VAL_W'($urandom_range(0, ceiling));
        endcase
    endfunction

    // One random phase under fixed register values
    task automatic run_phase(input logic [CFG_W-1:0] interval_value,
                             input logic [CFG_W-1:0] limit_value,
                             input int count, input int tick_pct,
                             input int unsigned ceiling);
        logic cmd;
        write_register(REG_AVERAGE_INTERVAL, interval_value);
        write_register(REG_DISPLAY_LIMIT, limit_value);
        repeat (count)
        begin
            cmd = ($urandom_range(0, 99) < tick_pct) ? CMD_TICK : CMD_SAMPLE;
            // ticks carry a junk sample that must be ignored
            send_request(cmd, cmd == CMD_TICK ? 16'($urandom_range(0, 65535))
                                              : pick_sample(ceiling));
        end
        drain();
    endtask

    // Stimulus
    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_write_en = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset register values: display steps on every tick while on target
        send_request(CMD_SAMPLE, 16'hFFFF);
        send_request(CMD_TICK,   16'h5A5A);
        send_request(CMD_TICK,   16'hFFFF);
        send_request(CMD_SAMPLE, 16'h0000);
        send_request(CMD_TICK,   16'h0000);
        drain();

        // Window advances every tick; fill it with full-scale samples
        write_register(REG_AVERAGE_INTERVAL, '0);
        write_register(REG_DISPLAY_LIMIT, 10'h3FF);
        send_request(CMD_SAMPLE, 16'hFFFF);
        for (int k = 0; k < WINDOW; k++)
            send_request(CMD_TICK, (k % 2 == 0) ? 16'hA5A5 : 16'h5A5A);
        send_request(CMD_SAMPLE, 16'h0001);
        send_request(CMD_TICK,   16'hFFFF);
        send_request(CMD_SAMPLE, 16'h0000);
        send_request(CMD_TICK,   16'h0000);
        drain();

        // Fast window, full limit, full-range samples
        run_phase(10'h000, 10'h3FF, 110, 80, 16'hFFFF);
        // Upper bits of the interval write dropped: 255 never advances; limit lowered to zero
        run_phase(10'h3FF, 10'h000, 100, 85, 16'hFFFF);
        // Small samples for varied gaps, no idling on either side
        steady = 1'b1;
        run_phase(10'($urandom_range(1, 4)), 10'($urandom_range(0, 1023)), 120, 80, 400);
        steady = 1'b0;
        run_phase(10'h001, 10'h214, 120, 80, 400);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
